// ===== rtl/core/error_report_throttle_assert.svh =====
// ----------------------------------------------------------------------------
// error_report_throttle_assert.svh
// assertion macros used by the error report throttle checker
// ----------------------------------------------------------------------------
`ifndef ERROR_REPORT_THROTTLE_ASSERT_SVH
`define ERROR_REPORT_THROTTLE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define ERT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ERT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/core/ert_pkg.sv =====
// ----------------------------------------------------------------------------
// ert_pkg
// types and constants of the error report throttle
// ----------------------------------------------------------------------------
package ert_pkg;

	localparam int NUM_CODES     = 18;
	localparam int REPORT_BUDGET = 10;
	localparam int TIME_W        = 32;
	localparam int CNT_W         = 32;
	localparam int CODE_W        = 5;
	localparam int CODE_AW       = $clog2(NUM_CODES);
	localparam int BUDGET_W      = $clog2(REPORT_BUDGET + 1);
	localparam int INTERVAL_W    = 31;
	localparam int TICKS_PER_SEC = 100;

	localparam logic [CODE_W-1:0]     TIMEOUT_CODE   = CODE_W'(NUM_CODES - 1);
	localparam logic [CODE_W-1:0]     NUM_CODES_C    = CODE_W'(NUM_CODES);
	localparam logic [BUDGET_W-1:0]   BUDGET_FULL    = BUDGET_W'(REPORT_BUDGET);
	localparam logic [INTERVAL_W-1:0] INTERVAL_RESET =
		INTERVAL_W'(8 * 3600 * TICKS_PER_SEC);

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic [APB_ADDR_W-3:0] REG_TIMEOUT_INTERVAL = '0;

	typedef struct packed {
		logic                en;
		logic [CODE_AW-1:0]  addr;
		logic [BUDGET_W-1:0] data;
	} bud_wr_t;

	typedef struct packed {
		logic              report;
		logic [CNT_W-1:0]  pending_events;
		logic              repeat_valid;
		logic [CODE_W-1:0] repeat_code;
		logic [CNT_W-1:0]  repeat_times;
	} rpt_word_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == '1) ? v : v + CNT_W'(1);
	endfunction

endpackage

// ===== rtl/core/ert_evt_if.sv =====
// ----------------------------------------------------------------------------
// ert_evt_if
// error event channel: code and tick time
// ----------------------------------------------------------------------------
interface ert_evt_if;
	logic                         valid;
	logic                         ready;
	logic [ert_pkg::CODE_W-1:0]   error_code;
	logic [ert_pkg::TIME_W-1:0]   now_ticks;

	modport source (output valid, output error_code, output now_ticks, input ready);
	modport sink   (input valid, input error_code, input now_ticks, output ready);
endinterface

// ===== rtl/core/ert_rpt_if.sv =====
// ----------------------------------------------------------------------------
// ert_rpt_if
// report decision channel
// ----------------------------------------------------------------------------
interface ert_rpt_if;
	logic                        valid;
	logic                        ready;
	logic                        report;
	logic [ert_pkg::CNT_W-1:0]   pending_events;
	logic                        repeat_valid;
	logic [ert_pkg::CODE_W-1:0]  repeat_code;
	logic [ert_pkg::CNT_W-1:0]   repeat_times;

	modport source (output valid, output report, output pending_events,
		output repeat_valid, output repeat_code, output repeat_times, input ready);
	modport sink   (input valid, input report, input pending_events,
		input repeat_valid, input repeat_code, input repeat_times, output ready);
endinterface

// ===== rtl/core/ert_budget_ram.sv =====
// ----------------------------------------------------------------------------
// ert_budget_ram
// per-code report budget store with registered read and write forwarding
// ----------------------------------------------------------------------------
module ert_budget_ram (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             rd_en,
	input  logic [ert_pkg::CODE_AW-1:0]      rd_addr,
	input  ert_pkg::bud_wr_t                 wr,
	output logic [ert_pkg::BUDGET_W-1:0]     rd_budget
);

	logic [ert_pkg::BUDGET_W-1:0] mem [ert_pkg::NUM_CODES];
	logic [ert_pkg::NUM_CODES-1:0] vld_q;
	logic [ert_pkg::BUDGET_W-1:0] mem_rd_s1;
	logic                         vld_rd_s1;
	logic                         fwd_hit_s1;
	logic [ert_pkg::BUDGET_W-1:0] fwd_data_s1;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			mem_rd_s1   <= mem[rd_addr];
			fwd_data_s1 <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			vld_rd_s1  <= 1'b0;
			fwd_hit_s1 <= 1'b0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_rd_s1  <= vld_q[rd_addr];
				fwd_hit_s1 <= wr.en && (wr.addr == rd_addr);
			end
		end
	end

	// entries never written still hold the full budget
	always_comb begin
		if (fwd_hit_s1) begin
			rd_budget = fwd_data_s1;
		end else if (vld_rd_s1) begin
			rd_budget = mem_rd_s1;
		end else begin
			rd_budget = ert_pkg::BUDGET_FULL;
		end
	end

endmodule

// ===== rtl/core/error_report_throttle.sv =====
// ----------------------------------------------------------------------------
// error_report_throttle
// decides per error event whether it is reported upstream
// ----------------------------------------------------------------------------
// evt (sink) carries one error word: error_code and now_ticks. rpt (source)
// returns exactly one word per event: the report flag, the pending timeout
// tally and the summary of the previous repeated code.
// timeout_report_interval is written over the APB port at byte address 0.
// after acceptance the event is held in the decision stage register and then
// in the output register, which drives rpt valid. throughput: one event per
// cycle while rpt is not stalled; the budget store is read in the acceptance
// cycle and written back when the event leaves the decision stage, with the
// write forwarded to a read of the same code issued in that cycle.
// reset: all codes regain their full budget, no previous code is known,
// counters clear, the interval returns to 2880000 ticks. the budget store
// needs no clearing pass, so events are taken right after reset.
// a stalled rpt keeps its word; one further event is held in the decision
// stage, then evt.ready drops until rpt moves again.
// ----------------------------------------------------------------------------
module error_report_throttle (
	input  logic                              clk,
	input  logic                              arst_n,
	ert_evt_if.sink                           evt,
	ert_rpt_if.source                         rpt,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [ert_pkg::APB_ADDR_W-1:0]    paddr,
	input  logic [ert_pkg::APB_DATA_W-1:0]    pwdata,
	output logic [ert_pkg::APB_DATA_W-1:0]    prdata,
	output logic                              pready
);

	logic [ert_pkg::INTERVAL_W-1:0] interval_q;
	logic                           reg_hit;

	logic                           s1_vld_q;
	logic [ert_pkg::CODE_W-1:0]     code_s1;
	logic [ert_pkg::TIME_W-1:0]     now_s1;
	logic                           s1_adv;
	logic                           acc;
	logic                           known_in;
	logic [ert_pkg::CODE_AW-1:0]    rd_addr;
	logic [ert_pkg::BUDGET_W-1:0]   budget;
	ert_pkg::bud_wr_t               bud_wr;

	logic [ert_pkg::CODE_W-1:0]     last_code_q;
	logic                           last_vld_q;
	logic [ert_pkg::CNT_W-1:0]      rep_cnt_q;
	logic [ert_pkg::TIME_W-1:0]     next_to_q;
	logic [ert_pkg::CNT_W-1:0]      sup_q;

	logic                           is_rep;
	logic                           is_to;
	logic                           late;
	logic                           want;
	logic                           known_s1;
	logic                           grant;
	logic [ert_pkg::TIME_W-1:0]     rearm;
	logic [ert_pkg::TIME_W-1:0]     diff;
	logic [ert_pkg::TIME_W-1:0]     next_to_d;
	logic [ert_pkg::CNT_W-1:0]      sup_inc;
	logic [ert_pkg::CNT_W-1:0]      sup_dec;
	logic [ert_pkg::CNT_W-1:0]      sup_d;
	ert_pkg::rpt_word_t             res;

	logic                           out_vld_q;
	ert_pkg::rpt_word_t             out_q;

	// configuration
	assign pready  = 1'b1;
	assign reg_hit = (paddr[ert_pkg::APB_ADDR_W-1:2] == ert_pkg::REG_TIMEOUT_INTERVAL);
	assign prdata  = reg_hit ? ert_pkg::APB_DATA_W'(interval_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= ert_pkg::INTERVAL_RESET;
		end else if (psel && penable && pwrite && reg_hit) begin
			interval_q <= pwdata[ert_pkg::INTERVAL_W-1:0];
		end
	end

	// acceptance and budget read
	assign s1_adv    = s1_vld_q && (!out_vld_q || rpt.ready);
	assign evt.ready = !s1_vld_q || s1_adv;
	assign acc       = evt.valid && evt.ready;
	assign known_in  = evt.error_code < ert_pkg::NUM_CODES_C;
	assign rd_addr   = known_in ? evt.error_code[ert_pkg::CODE_AW-1:0] : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_vld_q <= 1'b0;
		end else if (acc) begin
			s1_vld_q <= 1'b1;
		end else if (s1_adv) begin
			s1_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			code_s1 <= evt.error_code;
			now_s1  <= evt.now_ticks;
		end
	end

	ert_budget_ram u_budget (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (acc),
		.rd_addr   (rd_addr),
		.wr        (bud_wr),
		.rd_budget (budget)
	);

	// decision stage
	always_comb begin
		is_rep   = last_vld_q && (last_code_q == code_s1);
		is_to    = (code_s1 == ert_pkg::TIMEOUT_CODE);
		known_s1 = code_s1 < ert_pkg::NUM_CODES_C;
		rearm    = now_s1 + ert_pkg::TIME_W'(interval_q);
		diff     = next_to_q - now_s1;
		late     = is_to && is_rep && diff[ert_pkg::TIME_W-1];
		sup_inc  = (is_to && is_rep) ? ert_pkg::sat_inc(sup_q) : sup_q;
		sup_dec  = (late && (sup_inc != '0)) ? sup_inc - ert_pkg::CNT_W'(1) : sup_inc;
		next_to_d = (is_to && (!is_rep || late)) ? rearm : next_to_q;
		want     = !is_rep || late;
		grant    = want && known_s1 && (budget != '0);

		bud_wr.en   = s1_adv && grant;
		bud_wr.addr = code_s1[ert_pkg::CODE_AW-1:0];
		bud_wr.data = budget - ert_pkg::BUDGET_W'(1);

		res.report         = grant;
		res.pending_events = (grant && is_to) ? sup_dec : '0;
		res.repeat_valid   = grant && !is_rep && (rep_cnt_q != '0);
		res.repeat_code    = res.repeat_valid ? last_code_q : '0;
		res.repeat_times   = res.repeat_valid ? ert_pkg::sat_inc(rep_cnt_q) : '0;
		sup_d              = (grant && is_to) ? '0 : sup_dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_code_q <= '0;
			last_vld_q  <= 1'b0;
			rep_cnt_q   <= '0;
			next_to_q   <= '0;
			sup_q       <= '0;
		end else if (s1_adv) begin
			last_code_q <= code_s1;
			last_vld_q  <= 1'b1;
			rep_cnt_q   <= is_rep ? ert_pkg::sat_inc(rep_cnt_q) : '0;
			next_to_q   <= next_to_d;
			sup_q       <= sup_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (s1_adv) begin
			out_vld_q <= 1'b1;
		end else if (rpt.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q <= res;
		end
	end

	assign rpt.valid          = out_vld_q;
	assign rpt.report         = out_q.report;
	assign rpt.pending_events = out_q.pending_events;
	assign rpt.repeat_valid   = out_q.repeat_valid;
	assign rpt.repeat_code    = out_q.repeat_code;
	assign rpt.repeat_times   = out_q.repeat_times;

endmodule

// ===== rtl/core/ert_checker.sv =====
// ----------------------------------------------------------------------------
// ert_checker
// port-level checks of the report channel, bound to the top level
// ----------------------------------------------------------------------------
`include "error_report_throttle_assert.svh"

module ert_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          rpt_valid,
	input logic                          rpt_ready,
	input logic                          report,
	input logic [ert_pkg::CNT_W-1:0]     pending_events,
	input logic                          repeat_valid,
	input logic [ert_pkg::CNT_W-1:0]     repeat_times
);

	`ERT_ASSERT_IMP(a_summary_needs_report, clk, arst_n, rpt_valid && repeat_valid, report)
	`ERT_ASSERT_IMP(a_quiet_word_empty, clk, arst_n, rpt_valid && !report, (pending_events == '0) && !repeat_valid)
	`ERT_ASSERT_IMP(a_repeat_times_min, clk, arst_n, rpt_valid && repeat_valid, repeat_times > ert_pkg::CNT_W'(1))
	`ERT_ASSERT_NXT(a_stalled_word_stays, clk, arst_n, rpt_valid && !rpt_ready, rpt_valid)

endmodule

bind error_report_throttle ert_checker u_ert_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.rpt_valid      (rpt.valid),
	.rpt_ready      (rpt.ready),
	.report         (rpt.report),
	.pending_events (rpt.pending_events),
	.repeat_valid   (rpt.repeat_valid),
	.repeat_times   (rpt.repeat_times)
);
